/* design/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg: shared types and helpers for the shelf rectangle packer
// Holds the payload structs, configuration register codes and the rounding
// function used to report the packed atlas height.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int unsigned RECT_W   = 14;
  localparam int unsigned ID_W     = 64;
  localparam int unsigned DIM_W    = 15;
  localparam int unsigned PAD_W    = 8;
  localparam int unsigned STATE_W  = 16;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SUM_W    = 17;

  localparam logic [DIM_W-1:0] ATLAS_WIDTH_RST  = 15'd512;
  localparam logic [DIM_W-1:0] ATLAS_HEIGHT_RST = 15'd512;
  localparam logic [PAD_W-1:0] PADDING_RST      = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATLAS_WIDTH  = 2'd0,
    CFG_HEIGHT_LIMIT = 2'd1,
    CFG_PADDING      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [RECT_W-1:0] rect_width;
    logic [RECT_W-1:0] rect_height;
    logic [ID_W-1:0]   rect_id;
    logic              first_rect;
    logic              last_rect;
  } in_item_t;

  typedef struct packed {
    logic                placed;
    logic [RECT_W-1:0]   pos_x;
    logic [RECT_W-1:0]   pos_y;
    logic [ID_W-1:0]     out_id;
    logic [HEIGHT_W-1:0] packed_height;
    logic                all_fit;
    logic                is_last;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] atlas_width;
    logic [DIM_W-1:0] atlas_height_limit;
    logic [PAD_W-1:0] padding_px;
  } cfg_t;

  typedef struct packed {
    logic [STATE_W-1:0] cursor_x;
    logic [STATE_W-1:0] shelf_top;
    logic [STATE_W-1:0] shelf_height;
    logic               pack_failed;
  } pack_state_t;

  // Smallest power of two not below v, with 0 and 1 both giving 1.
  // The used height never exceeds 65534, so the result fits in SUM_W bits.
  function automatic logic [SUM_W-1:0] pow2_ceil(input logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] x;
    begin
      x = v - SUM_W'(1);
      x = x | (x >> 1);
      x = x | (x >> 2);
      x = x | (x >> 4);
      x = x | (x >> 8);
      x = x | (x >> 16);
      if (v <= SUM_W'(1)) begin
        pow2_ceil = SUM_W'(1);
      end else begin
        pow2_ceil = x + SUM_W'(1);
      end
    end
  endfunction

endpackage

/* design/shelf_rectangle_packer.sv */
// ----------------------------------------------------------------------------
// shelf_rectangle_packer: streaming shelf packer for a texture atlas
// Places rectangles left to right on shelves, reports placements, sticky
// failure and the rounded used height on the last rectangle.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------------
//   in_      | input     | in_valid/in_ready  | in_data  (srp_pkg::in_item_t)
//   out_     | output    | out_valid/out_ready| out_data (srp_pkg::out_item_t)
//   cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One rectangle per cycle sustained while the output is not stalled; an
// accepted transaction passes the input register, then the result register.
// The shelf state loop closes through the placement datapath.
// Reset is synchronous and clears both stage valids and the shelf state.
// A stalled result register holds the input stage, which still takes one
// more transaction while it is empty.
// ----------------------------------------------------------------------------
module shelf_rectangle_packer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  srp_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output srp_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srp_pkg::DIM_W-1:0]     cfg_data
);
  import srp_pkg::*;

  cfg_t        cfg;
  in_item_t    in_item_r;
  logic        in_valid_r;
  out_item_t   out_item_r;
  logic        out_valid_r;
  pack_state_t state_r;
  pack_state_t state_nxt;
  out_item_t   result;
  logic        advance;

  srp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  srp_place_calc u_calc (
    .item_i   (in_item_r),
    .cfg_i    (cfg),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .result_o (result)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

`ifndef SYNTHESIS
  a_sticky_fail: assert property (@(posedge clk) disable iff (!rst_n)
    advance && state_r.pack_failed && !in_item_r.first_rect |-> !result.placed)
    else $error("rectangle placed while the pack is failed");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed transaction produced no result");

  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("buffered transaction lost while stalled");

  a_fit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.all_fit |-> out_item_r.is_last &&
      out_item_r.packed_height != '0)
    else $error("fit verdict on a result that is not last");
`endif

endmodule

/* design/srp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// srp_cfg_regs: configuration register file
// Three writable registers for atlas width, height limit and padding.
// Writes to unused indexes are accepted and dropped.
// ----------------------------------------------------------------------------
module srp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srp_pkg::DIM_W-1:0]       cfg_data,
  output srp_pkg::cfg_t                   cfg_o
);
  import srp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ATLAS_WIDTH:  cfg_nxt.atlas_width        = cfg_data;
        CFG_HEIGHT_LIMIT: cfg_nxt.atlas_height_limit = cfg_data;
        CFG_PADDING:      cfg_nxt.padding_px         = cfg_data[PAD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.atlas_width        <= ATLAS_WIDTH_RST;
      cfg_r.atlas_height_limit <= ATLAS_HEIGHT_RST;
      cfg_r.padding_px         <= PADDING_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* design/srp_place_calc.sv */
// ----------------------------------------------------------------------------
// srp_place_calc: placement datapath
// From the buffered rectangle and the current shelf state, works out the
// placement, the next shelf state and the packed height report.
// ----------------------------------------------------------------------------
module srp_place_calc (
  input  srp_pkg::in_item_t     item_i,
  input  srp_pkg::cfg_t         cfg_i,
  input  srp_pkg::pack_state_t  state_i,
  output srp_pkg::pack_state_t  state_o,
  output srp_pkg::out_item_t    result_o
);
  import srp_pkg::*;

  localparam int unsigned CMP_W = SUM_W + 1;

  pack_state_t      s0;
  logic [CMP_W-1:0] w_e, h_e, p_e, aw_e, lim_e, pad2_e;
  logic [CMP_W-1:0] cx_e, top_e, sh_e;
  logic [CMP_W-1:0] cx_w, top_w, sh_w;
  logic [CMP_W-1:0] h_pad, sh_new;
  logic             too_big, wrap, over, placed;
  logic [SUM_W-1:0] used, full;

  always_comb begin
    // A start resets the shelf state before this rectangle is tried.
    s0 = state_i;
    if (item_i.first_rect) begin
      s0.cursor_x     = STATE_W'(cfg_i.padding_px);
      s0.shelf_top    = STATE_W'(cfg_i.padding_px);
      s0.shelf_height = '0;
      s0.pack_failed  = 1'b0;
    end

    w_e    = CMP_W'(item_i.rect_width);
    h_e    = CMP_W'(item_i.rect_height);
    p_e    = CMP_W'(cfg_i.padding_px);
    pad2_e = p_e << 1;
    aw_e   = CMP_W'(cfg_i.atlas_width);
    lim_e  = CMP_W'(cfg_i.atlas_height_limit);
    cx_e   = CMP_W'(s0.cursor_x);
    top_e  = CMP_W'(s0.shelf_top);
    sh_e   = CMP_W'(s0.shelf_height);

    h_pad   = h_e + pad2_e;
    too_big = (w_e + pad2_e > aw_e) || (h_pad > lim_e);
    wrap    = (cx_e + w_e + p_e) > aw_e;
    cx_w    = wrap ? p_e : cx_e;
    top_w   = wrap ? (top_e + sh_e) : top_e;
    sh_w    = wrap ? '0 : sh_e;
    over    = (top_w + h_e + p_e) > lim_e;
    placed  = !s0.pack_failed && !too_big && !over;
    sh_new  = (h_pad > sh_w) ? h_pad : sh_w;

    state_o = s0;
    state_o.pack_failed = s0.pack_failed | too_big | over;
    if (placed) begin
      state_o.cursor_x     = STATE_W'(cx_w + w_e + pad2_e);
      state_o.shelf_top    = STATE_W'(top_w);
      state_o.shelf_height = STATE_W'(sh_new);
    end

    used = SUM_W'(state_o.shelf_top) + SUM_W'(state_o.shelf_height);
    full = pow2_ceil(used);

    result_o.placed        = placed;
    result_o.pos_x         = placed ? RECT_W'(cx_w) : '0;
    result_o.pos_y         = placed ? RECT_W'(top_w) : '0;
    result_o.out_id        = item_i.rect_id;
    result_o.is_last       = item_i.last_rect;
    result_o.packed_height = '0;
    result_o.all_fit       = 1'b0;
    if (item_i.last_rect) begin
      // The fit verdict compares the unsaturated height.
      result_o.all_fit       = !state_o.pack_failed && (CMP_W'(full) <= lim_e);
      result_o.packed_height = full[SUM_W-1] ? HEIGHT_W'(1 << (HEIGHT_W - 1))
                                             : full[HEIGHT_W-1:0];
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the shelf rectangle packer
// Runs a short directed table of corner cases, then random atlas packs
// under changing register settings. Each result is checked against the
// table's expected value or a behavioral model of the packer in this bench.
// ----------------------------------------------------------------------------
module tb;
  import srp_pkg::*;

  localparam int QUIET_LIMIT = 200;
  localparam int RANDOM_RECTS = 1750;

  localparam cfg_t NO_CFG    = '0;
  localparam cfg_t WIDEST    = '{15'd16384, 15'd16384, 8'd255};
  localparam cfg_t TINY      = '{15'd1, 15'd1, 8'd0};
  localparam cfg_t TINY_PAD  = '{15'd1, 15'd1, 8'd255};
  localparam cfg_t MID_PAD   = '{15'd512, 15'd512, 8'd3};
  localparam cfg_t NARROWED  = '{15'd256, 15'd512, 8'd0};

  typedef struct {
    bit        set_cfg;
    cfg_t      cfg;
    in_item_t  rect;
    bit        typed;
    out_item_t want;
  } row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;

  // Register mirror and shelf state of the bench's own packer model.
  cfg_t         regs = '{ATLAS_WIDTH_RST, ATLAS_HEIGHT_RST, PADDING_RST};
  logic [15:0]  cursor_x = '0;
  logic [15:0]  shelf_top = '0;
  logic [15:0]  shelf_h = '0;
  bit           failed = 1'b0;

  out_item_t pending_placements[$];
  row_t      steps[$];
  bit        no_idle = 1'b0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  shelf_rectangle_packer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Places one rectangle and returns the result the packer should give.
  function automatic out_item_t place_rect(input in_item_t r);
    int unsigned w, h, p, cx, top, sh, full;
    out_item_t res;
    w = r.rect_width;
    h = r.rect_height;
    p = regs.padding_px;
    res = '0;
    if (r.first_rect) begin
      cursor_x = 16'(p);
      shelf_top = 16'(p);
      shelf_h = '0;
      failed = 1'b0;
    end
    if (!failed) begin
      if (w + 2 * p > regs.atlas_width || h + 2 * p > regs.atlas_height_limit) begin
        failed = 1'b1;
      end else begin
        cx = cursor_x;
        top = shelf_top;
        sh = shelf_h;
        if (cx + w + p > regs.atlas_width) begin
          cx = p;
          top = top + sh;
          sh = 0;
        end
        if (top + h + p > regs.atlas_height_limit) begin
          failed = 1'b1;
        end else begin
          res.placed = 1'b1;
          res.pos_x = cx[13:0];
          res.pos_y = top[13:0];
          cursor_x = 16'(cx + w + 2 * p);
          shelf_top = 16'(top);
          if (h + 2 * p > sh) begin
            sh = h + 2 * p;
          end
          shelf_h = 16'(sh);
        end
      end
    end
    res.out_id = r.rect_id;
    res.is_last = r.last_rect;
    if (r.last_rect) begin
      full = 1;
      while (full < int'(shelf_top) + int'(shelf_h)) begin
        full = full << 1;
      end
      res.all_fit = !failed && full <= regs.atlas_height_limit;
      res.packed_height = (full > 32768) ? 16'h8000 : full[15:0];
    end
    return res;
  endfunction

  function automatic void add_row(input bit set_cfg, input cfg_t c, input int w, input int h,
                                  input logic [63:0] id, input bit first, input bit last,
                                  input bit typed, input bit placed, input int px,
                                  input int py, input int ph, input bit fit);
    row_t s;
    s.set_cfg = set_cfg;
    s.cfg = c;
    s.rect = '{14'(w), 14'(h), id, first, last};
    s.typed = typed;
    s.want = '{placed, 14'(px), 14'(py), id, 16'(ph), fit, last};
    steps = {steps, s};
  endfunction

  // Draws an atlas dimension, with both ends of the range now and then.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return 15'd1;
      1: return 15'd16384;
      2, 3: return 15'($urandom_range(64, 1024));
      default: return 15'($urandom_range(1, 16384));
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_rect(input in_item_t r, input bit typed, input out_item_t want);
    int gap;
    out_item_t guess;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    guess = place_rect(r);
    pending_placements = {pending_placements, (typed ? want : guess)};
  endtask

  // Holds the input side until every placement has come back and the
  // two-stage pipeline has emptied.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input cfg_t c);
    cfg_idx_t         idx [3];
    logic [DIM_W-1:0] val [3];
    idx = '{CFG_ATLAS_WIDTH, CFG_HEIGHT_LIMIT, CFG_PADDING};
    val = '{c.atlas_width, c.atlas_height_limit, DIM_W'(c.padding_px)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    regs = c;
  endtask

  // Result side: a random stall before each result, none in burst phases.
  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_placements.size() == 0) begin
        $error("unexpected result transaction, id %0h", out_data.out_id);
        mismatches++;
      end else begin
        want = pending_placements.pop_front();
        check_field("placed", want.placed, out_data.placed);
        check_field("pos_x", want.pos_x, out_data.pos_x);
        check_field("pos_y", want.pos_y, out_data.pos_y);
        check_field("out_id", want.out_id, out_data.out_id);
        check_field("packed_height", want.packed_height, out_data.packed_height);
        check_field("all_fit", want.all_fit, out_data.all_fit);
        check_field("is_last", want.is_last, out_data.is_last);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int        sent;
    int        phase_end;
    int        len;
    int unsigned wtyp, htyp, wbig, hbig;
    bit        big;
    cfg_t      c;
    in_item_t  r;

    // Reset register values, then the special cases one by one.
    add_row(0, NO_CFG, 10, 20, 64'd1, 0, 0, 1, 1, 0, 0, 0, 0);      // before any start
    add_row(0, NO_CFG, 20, 5, 64'd2, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, NO_CFG, 0, 0, 64'd0, 1, 1, 1, 1, 0, 0, 1, 1);        // empty height
    add_row(0, NO_CFG, 16383, 16383, '1, 1, 0, 1, 0, 0, 0, 0, 0);   // too large
    add_row(0, NO_CFG, 1, 1, 64'd5, 0, 1, 1, 0, 0, 0, 1, 0);        // failure is sticky
    add_row(0, NO_CFG, 512, 512, 64'd6, 1, 1, 1, 1, 0, 0, 512, 1);  // exact fit
    add_row(0, NO_CFG, 300, 100, 64'd7, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, NO_CFG, 300, 50, 64'd8, 0, 0, 0, 0, 0, 0, 0, 0);     // wraps to a new shelf
    add_row(0, NO_CFG, 100, 450, 64'd9, 0, 0, 0, 0, 0, 0, 0, 0);    // shelf overflow
    add_row(0, NO_CFG, 1, 1, 64'd10, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, NO_CFG, 513, 1, 64'd11, 1, 0, 1, 0, 0, 0, 0, 0);
    add_row(0, NO_CFG, 1, 513, 64'd12, 1, 1, 1, 0, 0, 0, 1, 0);
    // Largest atlas and padding: the used height rounds up to the top of the field.
    add_row(1, WIDEST, 0, 15874, 64'd13, 1, 1, 1, 1, 255, 255, 32768, 0);
    add_row(0, NO_CFG, 15874, 0, 64'd14, 1, 0, 1, 1, 255, 255, 0, 0);
    add_row(0, NO_CFG, 1, 1, 64'd15, 0, 1, 0, 0, 0, 0, 0, 0);
    add_row(0, NO_CFG, 1, 1, 64'h8000_0000_0000_0001, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, TINY, 1, 1, 64'd17, 1, 1, 1, 1, 0, 0, 1, 1);
    add_row(0, NO_CFG, 1, 1, 64'd18, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, NO_CFG, 2, 1, 64'd19, 1, 1, 1, 0, 0, 0, 1, 0);
    add_row(1, TINY_PAD, 0, 0, 64'd20, 1, 1, 1, 0, 0, 0, 256, 0);
    add_row(1, MID_PAD, 50, 60, 64'd21, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, NO_CFG, 60, 10, 64'd22, 0, 0, 0, 0, 0, 0, 0, 0);
    // Registers change in the middle of a pack; the shelf state carries over.
    add_row(1, NARROWED, 40, 40, 64'd23, 0, 1, 0, 0, 0, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      if (steps[i].set_cfg) begin
        quiesce();
        set_config(steps[i].cfg);
      end
      send_rect(steps[i].rect, steps[i].typed, steps[i].want);
    end

    sent = 0;
    while (sent < RANDOM_RECTS) begin
      quiesce();
      c.atlas_width = pick_dim();
      c.atlas_height_limit = pick_dim();
      case ($urandom_range(0, 5))
        0: c.padding_px = 8'd0;
        1: c.padding_px = 8'd255;
        default: c.padding_px = 8'($urandom_range(0, 6));
      endcase
      set_config(c);
      no_idle = ($urandom_range(0, 3) == 0);
      phase_end = sent + $urandom_range(100, 250);
      wbig = (c.atlas_width > 16383) ? 16383 : c.atlas_width;
      hbig = (c.atlas_height_limit > 16383) ? 16383 : c.atlas_height_limit;
      wtyp = wbig / 4;
      htyp = hbig / 8;
      while (sent < phase_end) begin
        if ($urandom_range(0, 59) == 0) begin
          quiesce();
        end
        if ($urandom_range(0, 6) == 0) begin
          // Unstructured transaction with every field drawn over its full range.
          r.rect_width = 14'($urandom);
          r.rect_height = 14'($urandom);
          r.rect_id = {$urandom, $urandom};
          r.first_rect = 1'($urandom);
          r.last_rect = 1'($urandom);
          send_rect(r, 1'b0, '0);
          sent++;
        end else begin
          // One atlas pack, sometimes missing its start or its end.
          len = $urandom_range(1, 30);
          for (int k = 0; k < len; k++) begin
            big = ($urandom_range(0, 15) == 0);
            r.rect_width = 14'($urandom_range(0, big ? wbig : wtyp));
            r.rect_height = 14'($urandom_range(0, big ? hbig : htyp));
            r.rect_id = {$urandom, $urandom};
            r.first_rect = (k == 0) && ($urandom_range(0, 9) != 0);
            r.last_rect = (k == len - 1) && ($urandom_range(0, 9) != 0);
            send_rect(r, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
